FILE: design/icc_pkg.sv
// ----------------------------------------------------------------------------
// icc_pkg: shared types, constants and helpers for the ID check core
// Weight and check-character tables, small constant-divisor helpers, status
// codes and the job record passed from the front end to the emitter.
// ----------------------------------------------------------------------------
package icc_pkg;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_LENGTH = 3'd1;
    localparam logic [2:0] STATUS_BAD_CHAR   = 3'd2;
    localparam logic [2:0] STATUS_BAD_CHECK  = 3'd3;
    localparam logic [2:0] STATUS_BAD_CENT   = 3'd4;
    localparam logic [2:0] STATUS_BAD_DATE   = 3'd5;

    localparam logic [7:0] CHAR_0 = 8'h30;
    localparam logic [7:0] CHAR_9 = 8'h39;
    localparam logic [7:0] CHAR_X = 8'h58;

    localparam logic [4:0] LEN_SHORT = 5'd15;
    localparam logic [4:0] LEN_LONG  = 5'd18;
    localparam logic [4:0] POS_LAST  = 5'd17;
    localparam logic [4:0] POS_SAT   = 5'd19;
    localparam logic [4:0] DATE_POS  = 5'd6;

    localparam logic [6:0] RESET_CENTURY = 7'd19;

    typedef struct packed {
        logic [2:0]       status;
        logic [17:0][7:0] chars;
    } job_t;

    // position weights of the MOD 11-2 sum
    function automatic logic [3:0] weight(input logic [4:0] pos);
        logic [3:0] w;
        case (pos)
            5'd0:    w = 4'd7;
            5'd1:    w = 4'd9;
            5'd2:    w = 4'd10;
            5'd3:    w = 4'd5;
            5'd4:    w = 4'd8;
            5'd5:    w = 4'd4;
            5'd6:    w = 4'd2;
            5'd7:    w = 4'd1;
            5'd8:    w = 4'd6;
            5'd9:    w = 4'd3;
            5'd10:   w = 4'd7;
            5'd11:   w = 4'd9;
            5'd12:   w = 4'd10;
            5'd13:   w = 4'd5;
            5'd14:   w = 4'd8;
            5'd15:   w = 4'd4;
            5'd16:   w = 4'd2;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] check_char(input logic [3:0] sum);
        logic [7:0] c;
        case (sum)
            4'd0:    c = 8'h31;
            4'd1:    c = 8'h30;
            4'd2:    c = CHAR_X;
            4'd3:    c = 8'h39;
            4'd4:    c = 8'h38;
            4'd5:    c = 8'h37;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h35;
            4'd8:    c = 8'h34;
            4'd9:    c = 8'h33;
            4'd10:   c = 8'h32;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // x mod 11 for x < 128, by reciprocal multiply (373 / 4096)
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [15:0] p;
        logic [3:0]  q;
        logic [6:0]  r;
        p = 16'(x) * 16'd373;
        q = p[15:12];
        r = x - 7'(q) * 7'd11;
        return r[3:0];
    endfunction

    // x / 10 for x < 128, by reciprocal multiply (205 / 2048)
    function automatic logic [3:0] div10(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] x);
        logic [6:0] r;
        r = x - 7'(div10(x)) * 7'd10;
        return r[3:0];
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return CHAR_0 + 8'(d);
    endfunction

endpackage

FILE: design/icc_front.sv
// ----------------------------------------------------------------------------
// icc_front: character intake and number judgement
// Stores characters, keeps running MOD 11 sums, then after the final
// character splits the birth year and judges the number into a job record.
// ----------------------------------------------------------------------------
module icc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [39:0]   s_tdata,
    input  logic          s_tlast,
    input  logic [6:0]    century,
    output logic          push_valid,
    input  logic          push_ready,
    output icc_pkg::job_t push_data
);
    import icc_pkg::*;

    localparam logic [1:0] PH_ACCEPT = 2'd0;
    localparam logic [1:0] PH_SPLIT  = 2'd1;
    localparam logic [1:0] PH_JUDGE  = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [3:0]  dsum_reg, dsum_next;
    logic [3:0]  usum_reg, usum_next;
    logic        err_reg, err_next;
    logic [7:0]  store_reg [18];
    logic [13:0] year_reg;
    logic [6:0]  month_reg;
    logic [6:0]  day_reg;
    logic [7:0]  hund_reg;
    logic [6:0]  rem_reg;

    logic [7:0]  id_char;
    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [3:0]  w_direct;
    logic [3:0]  w_upg;
    logic [26:0] year_prod;
    logic [7:0]  hund;
    logic        push_fire;

    logic [3:0]  cent_t, cent_o, usum_fin;
    logic        check_ok, date_ok, date15_ok, date18_ok, long_num;
    logic [2:0]  status;
    job_t        job;

    assign id_char   = s_tdata[7:0];
    assign s_tready  = (phase_reg == PH_ACCEPT);
    assign accept    = s_tvalid && s_tready;
    assign push_fire = push_valid && push_ready;

    always_comb
    begin
        is_digit  = (id_char >= CHAR_0) && (id_char <= CHAR_9);
        digit     = is_digit ? id_char[3:0] : 4'd0;
        w_direct  = weight(pos_reg);
        w_upg     = (pos_reg < 5'd6) ? weight(pos_reg) : weight(pos_reg + 5'd2);
        dsum_next = dsum_reg;
        usum_next = usum_reg;
        err_next  = err_reg;
        pos_next  = pos_reg;
        if (accept)
        begin
            if (pos_reg < LEN_LONG)
            begin
                if (!is_digit && !(id_char == CHAR_X && pos_reg == POS_LAST))
                    err_next = 1'b1;
                if (pos_reg < POS_LAST)
                    dsum_next = mod11(7'(digit * w_direct) + 7'(dsum_reg));
                if (pos_reg < LEN_SHORT)
                    usum_next = mod11(7'(digit * w_upg) + 7'(usum_reg));
            end
            if (pos_reg < POS_SAT)
                pos_next = pos_reg + 5'd1;
        end
        else if (push_fire)
        begin
            // number handed over: start the next one afresh
            dsum_next = 4'd0;
            usum_next = 4'd0;
            err_next  = 1'b0;
            pos_next  = 5'd0;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_ACCEPT:
                if (accept && s_tlast)
                    phase_next = PH_SPLIT;
            PH_SPLIT:
                phase_next = PH_JUDGE;
            PH_JUDGE:
                if (push_ready)
                    phase_next = PH_ACCEPT;
            default:
                phase_next = PH_ACCEPT;
        endcase
    end

    // year / 100 by reciprocal multiply, exact for 14-bit years
    assign year_prod = 27'(year_reg) * 27'd5243;
    assign hund      = year_prod[26:19];

    always_comb
    begin
        long_num  = (pos_reg == LEN_LONG);
        cent_t    = mod10(7'(div10(century)));
        cent_o    = mod10(century);
        usum_fin  = mod11(7'(usum_reg) + 7'({cent_t, 1'b0}) + 7'(cent_o));
        check_ok  = (store_reg[17] == check_char(dsum_reg));

        date15_ok = (store_reg[6]  == digit_char(div10(rem_reg)))
                 && (store_reg[7]  == digit_char(mod10(rem_reg)))
                 && (store_reg[8]  == digit_char(div10(month_reg)))
                 && (store_reg[9]  == digit_char(mod10(month_reg)))
                 && (store_reg[10] == digit_char(div10(day_reg)))
                 && (store_reg[11] == digit_char(mod10(day_reg)));
        date18_ok = (store_reg[6]  == digit_char(div10(hund_reg[6:0])))
                 && (store_reg[7]  == digit_char(mod10(hund_reg[6:0])))
                 && (store_reg[8]  == digit_char(div10(rem_reg)))
                 && (store_reg[9]  == digit_char(mod10(rem_reg)))
                 && (store_reg[10] == digit_char(div10(month_reg)))
                 && (store_reg[11] == digit_char(mod10(month_reg)))
                 && (store_reg[12] == digit_char(div10(day_reg)))
                 && (store_reg[13] == digit_char(mod10(day_reg)));
        date_ok   = long_num ? date18_ok : date15_ok;

        if (pos_reg != LEN_SHORT && pos_reg != LEN_LONG)
            status = STATUS_BAD_LENGTH;
        else if (err_reg)
            status = STATUS_BAD_CHAR;
        else if (long_num && !check_ok)
            status = STATUS_BAD_CHECK;
        else if (hund_reg != {1'b0, century})
            status = STATUS_BAD_CENT;
        else if (hund_reg > 8'd99 || month_reg > 7'd99 || day_reg > 7'd99 || !date_ok)
            status = STATUS_BAD_DATE;
        else
            status = STATUS_OK;

        job.status = status;
        for (int i = 0; i < 18; i++)
            job.chars[i] = store_reg[i];
        if (!long_num)
        begin
            // insert the century after position 5 and append a fresh check
            job.chars[6] = digit_char(cent_t);
            job.chars[7] = digit_char(cent_o);
            for (int i = 8; i < 17; i++)
                job.chars[i] = store_reg[i - 2];
            job.chars[17] = check_char(usum_fin);
        end
    end

    assign push_valid = (phase_reg == PH_JUDGE);
    assign push_data  = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ACCEPT;
            pos_reg   <= 5'd0;
            dsum_reg  <= 4'd0;
            usum_reg  <= 4'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            dsum_reg  <= dsum_next;
            usum_reg  <= usum_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && pos_reg < LEN_LONG)
            store_reg[pos_reg] <= id_char;
        if (accept && s_tlast)
        begin
            year_reg  <= s_tdata[21:8];
            month_reg <= s_tdata[28:22];
            day_reg   <= s_tdata[35:29];
        end
        if (phase_reg == PH_SPLIT)
        begin
            hund_reg <= hund;
            rem_reg  <= 7'(year_reg - 14'(hund * 8'd100));
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_SAT)
        else $error("character count beyond saturation");

    a_clear_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        push_fire |=> (pos_reg == 5'd0 && !err_reg && dsum_reg == 4'd0))
        else $error("running state not cleared after hand-over");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        (push_fire && push_data.status == STATUS_OK)
            |-> (pos_reg == LEN_SHORT || pos_reg == LEN_LONG))
        else $error("accepted number with illegal length");
`endif

endmodule

FILE: design/icc_queue.sv
// ----------------------------------------------------------------------------
// icc_queue: two-entry job queue
// Holds judged numbers between the front end and the emitter.
// ----------------------------------------------------------------------------
module icc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  icc_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output icc_pkg::job_t pop_data
);
    import icc_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

FILE: design/icc_back.sv
// ----------------------------------------------------------------------------
// icc_back: result emitter
// Turns each job into one status transfer or eighteen character transfers
// through a registered output stage.
// ----------------------------------------------------------------------------
module icc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  icc_pkg::job_t pop_data,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata,
    output logic          m_tlast,
    output logic          m_tuser
);
    import icc_pkg::*;

    logic [4:0] k_reg, k_next;
    logic       out_valid_reg;
    logic [2:0] out_status_reg;
    logic [7:0] out_char_reg;
    logic       out_present_reg;
    logic       out_last_reg;
    logic       load;
    logic       head_ok;
    logic       head_last;

    assign head_ok   = (pop_data.status == STATUS_OK);
    assign head_last = !head_ok || (k_reg == POS_LAST);
    assign load      = pop_valid && (!out_valid_reg || m_tready);
    assign pop_ready = load && head_last;

    always_comb
    begin
        k_next = k_reg;
        if (load)
            k_next = head_last ? 5'd0 : k_reg + 5'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_status_reg  <= pop_data.status;
            out_char_reg    <= head_ok ? pop_data.chars[k_reg] : 8'h00;
            out_present_reg <= head_ok;
            out_last_reg    <= head_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_char_reg, out_status_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_present_reg;

`ifndef SYNTHESIS
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= POS_LAST)
        else $error("emit counter out of range");

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tlast && m_tdata[2:0] != STATUS_OK))
        else $error("status transfer not single or carries ok");

    a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[2:0] == STATUS_OK))
        else $error("character transfer with failing status");
`endif

endmodule

FILE: design/id_number_check_and_upgrade_core.sv
// ----------------------------------------------------------------------------
// id_number_check_and_upgrade_core: identity number check and upgrade
// Checks a 15 or 18 character identity number against the birth date and
// the configured century, and emits the 18-character form when valid.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   id char, birth date; s_tlast = final
//  m_*       out        m_tvalid/m_tready   status, out char; tuser, tlast
//  cfg_*     in         cfg_valid/cfg_ready accepted century
//
//  One character is taken per cycle while s_tready is high. After the final
//  character the front end runs year split, then judgement, then takes more.
//  The emitter sends 18 transfers per valid number, one per rejected number,
//  one per cycle if not stalled; a two-entry job queue lets intake run ahead
//  of emission. Reset clears all control state; the century returns to 19.
//  A stalled output holds its transfer and the emitter behind it; with both
//  queue entries taken the front end holds in judgement and drops s_tready.
// ----------------------------------------------------------------------------
module id_number_check_and_upgrade_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // id_char[7:0], birth_year[21:8],
                                   // birth_month[28:22], birth_day[35:29], zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[2:0], out_char[10:3], zero
    output logic        m_tlast,
    output logic        m_tuser,   // char_present[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);
    import icc_pkg::*;

    logic [6:0] century_reg;
    logic       push_valid, push_ready;
    logic       pop_valid, pop_ready;
    job_t       push_data, pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            century_reg <= RESET_CENTURY;
        else if (cfg_valid && cfg_ready)
            century_reg <= cfg_data;
    end

    icc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .century    (century_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    icc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    icc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
